@@ rtl/sitda_pkg.sv @@
package sitda_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [7:0] char_type;

   localparam int unsigned NUMBER_WIDTH = 16;

   localparam char_type CHAR_ZERO  = 8'd48;
   localparam char_type CHAR_MINUS = 8'd45;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 16-bit x
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int unsigned RECIP_SHIFT = 19;

endpackage

@@ rtl/sitda_front.sv @@
module sitda_front #(
   parameter int DIGIT_COUNT = 5,
   parameter int TOP_WIDTH   = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sitda_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_neg,
   output logic [TOP_WIDTH-1:0]                out_top,
   output sitda_pkg::digit_type [DIGIT_COUNT-1:0] out_digits
);
   import sitda_pkg::*;

   localparam int DC = DIGIT_COUNT;

   logic                    vld_ff [0:DC];
   logic                    neg_ff [0:DC];
   logic [NUMBER_WIDTH-1:0] val_ff [0:DC-1];
   digit_type [DC-1:0]      dig_ff [1:DC];
   logic                    rdy    [0:DC+1];

   logic [NUMBER_WIDTH-1:0] raw;
   logic [NUMBER_WIDTH-1:0] mag_in;

   function automatic logic [TOP_WIDTH-1:0] top_digit(input digit_type [DC-1:0] d);
      logic [TOP_WIDTH-1:0] top;
      top = '0;
      for (int k = 1; k < DC; k++) begin
         if (d[k] != 4'd0) begin
            top = TOP_WIDTH'(k);
         end
      end
      return top;
   endfunction

   assign raw    = req_number;
   assign mag_in = raw[NUMBER_WIDTH-1] ? (NUMBER_WIDTH'(0) - raw) : raw;

   // a stage takes new data when empty or when its successor moves
   assign rdy[DC+1] = out_ready;
   for (genvar s = 0; s <= DC; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end
   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         neg_ff[0] <= raw[NUMBER_WIDTH-1];
         val_ff[0] <= mag_in;
      end
   end

   for (genvar s = 1; s <= DC; s++) begin : g_stage
      logic [2*NUMBER_WIDTH-1:0] prod;
      logic [NUMBER_WIDTH-1:0]   quo;
      logic [NUMBER_WIDTH-1:0]   rem;
      digit_type [DC-1:0]        dig_in;

      assign prod = val_ff[s-1] * RECIP_TEN;
      assign quo  = NUMBER_WIDTH'(prod >> RECIP_SHIFT);
      assign rem  = val_ff[s-1] - ((quo << 3) + (quo << 1));

      if (s == 1) begin : g_first
         always_comb begin
            dig_in    = '0;
            dig_in[0] = rem[3:0];
         end
      end else begin : g_next
         always_comb begin
            dig_in      = dig_ff[s-1];
            dig_in[s-1] = rem[3:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            neg_ff[s] <= neg_ff[s-1];
            dig_ff[s] <= dig_in;
         end
      end

      if (s < DC) begin : g_val
         always_ff @(posedge clock) begin
            if (rdy[s]) begin
               val_ff[s] <= quo;
            end
         end
      end
   end

   assign out_valid  = vld_ff[DC];
   assign out_neg    = neg_ff[DC];
   assign out_digits = dig_ff[DC];
   assign out_top    = top_digit(dig_ff[DC]);

endmodule

@@ rtl/sitda_queue.sv @@
module sitda_queue #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/sitda_back.sv @@
module sitda_back #(
   parameter int DIGIT_COUNT = 5,
   parameter int TOP_WIDTH   = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   head_valid,
   output logic                                   head_pop,
   input  logic                                   head_neg,
   input  logic [TOP_WIDTH-1:0]                   head_top,
   input  sitda_pkg::digit_type [DIGIT_COUNT-1:0] head_digits,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sitda_pkg::char_type                    rsp_text_byte,
   output logic                                   rsp_final_byte
);
   import sitda_pkg::*;

   logic                         busy_ff, busy_in;
   logic                         sign_ff, sign_in;
   logic [TOP_WIDTH-1:0]         pos_ff, pos_in;
   digit_type [DIGIT_COUNT-1:0]  dig_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   char_type                     rsp_text_byte_ff, rsp_text_byte_in;
   logic                         rsp_final_byte_ff, rsp_final_byte_in;

   logic                         advance, emit;
   logic                         src_sign;
   logic [TOP_WIDTH-1:0]         src_pos;
   digit_type [DIGIT_COUNT-1:0]  src_dig;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign emit     = advance && (busy_ff || head_valid);
   assign head_pop = advance && !busy_ff && head_valid;

   // work from the current number, or straight from the queue head when free
   assign src_sign = busy_ff ? sign_ff : head_neg;
   assign src_pos  = busy_ff ? pos_ff  : head_top;
   assign src_dig  = busy_ff ? dig_ff  : head_digits;

   always_comb begin
      busy_in           = busy_ff;
      sign_in           = sign_ff;
      pos_in            = pos_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_text_byte_in  = rsp_text_byte_ff;
      rsp_final_byte_in = rsp_final_byte_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (src_sign) begin
            rsp_text_byte_in  = CHAR_MINUS;
            rsp_final_byte_in = 1'b0;
            sign_in           = 1'b0;
            pos_in            = src_pos;
            busy_in           = 1'b1;
         end else begin
            rsp_text_byte_in  = CHAR_ZERO + char_type'(src_dig[src_pos]);
            rsp_final_byte_in = (src_pos == '0);
            sign_in           = 1'b0;
            pos_in            = src_pos - 1'b1;
            busy_in           = (src_pos != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff           <= sign_in;
      pos_ff            <= pos_in;
      rsp_text_byte_ff  <= rsp_text_byte_in;
      rsp_final_byte_ff <= rsp_final_byte_in;
      if (head_pop) begin
         dig_ff <= head_digits;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_byte  = rsp_text_byte_ff;
   assign rsp_final_byte = rsp_final_byte_ff;

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Signed 16-bit integer to decimal ASCII. Each request carries one two's
// complement number; the block answers with its decimal text, one ASCII byte
// per response: '-' first for a negative value, then the digits most
// significant first with leading zeros dropped (zero prints as "0", -32768
// as "-32768"). rsp_final_byte marks the last byte of each number. A new
// number can be taken every cycle while req_stall is low; the digit pipeline
// is followed by a QUEUE_DEPTH-entry queue. The byte-wide response register
// sets the sustained rate: one byte per cycle while rsp_stall is low, so a
// number occupies 1 to 6 bytes (sign plus significant digits), back to back
// with no gap between numbers already waiting in the queue.
module signed_int_to_decimal_ascii #(
   parameter int DIGIT_COUNT = 5,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [sitda_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [7:0]                               rsp_text_byte,
   output logic                                     rsp_final_byte
);
   import sitda_pkg::*;

   localparam int TOP_WIDTH   = $clog2(DIGIT_COUNT);
   localparam int ENTRY_WIDTH = 1 + TOP_WIDTH + 4 * DIGIT_COUNT;

   // front -> queue
   logic                         fr_valid, fr_ready, fr_neg;
   logic [TOP_WIDTH-1:0]         fr_top;
   digit_type [DIGIT_COUNT-1:0]  fr_digits;

   // queue -> back
   logic                         hd_valid, hd_pop, hd_neg;
   logic [TOP_WIDTH-1:0]         hd_top;
   digit_type [DIGIT_COUNT-1:0]  hd_digits;

   logic [ENTRY_WIDTH-1:0]       push_entry, head_entry;

   // Front: split sign from magnitude, peel one decimal digit per stage
   // and find the highest digit to print.
   sitda_front #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .TOP_WIDTH   (TOP_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .out_valid  (fr_valid),
      .out_ready  (fr_ready),
      .out_neg    (fr_neg),
      .out_top    (fr_top),
      .out_digits (fr_digits)
   );

   // Pack sign, top digit index and digits into one queue entry.
   assign push_entry = {fr_neg, fr_top, fr_digits};
   assign {hd_neg, hd_top, hd_digits} = head_entry;

   // Queue: decouple digit extraction from the byte-serial output so the
   // front keeps accepting while a long number is still being sent.
   sitda_queue #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_valid),
      .push_data  (push_entry),
      .push_ready (fr_ready),
      .pop        (hd_pop),
      .pop_valid  (hd_valid),
      .pop_data   (head_entry)
   );

   // Back: walk the entry one character per cycle, while rsp_stall is low, into the response register.
   sitda_back #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .TOP_WIDTH   (TOP_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (hd_valid),
      .head_pop       (hd_pop),
      .head_neg       (hd_neg),
      .head_top       (hd_top),
      .head_digits    (hd_digits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_final_byte (rsp_final_byte)
   );

endmodule

@@ rtl/sitda_checker.sv @@
module sitda_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_stall,
   input logic signed [sitda_pkg::NUMBER_WIDTH-1:0] req_number,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic [7:0]                               rsp_text_byte,
   input logic                                     rsp_final_byte
);
   import sitda_pkg::*;

   // hold a stalled request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_number))
      else $error("stalled request changed");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_byte)
                                 && $stable(rsp_final_byte))
      else $error("stalled response changed");

   // only a minus sign that never ends a run, or a decimal digit
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_byte == CHAR_MINUS && !rsp_final_byte) ||
                    (rsp_text_byte >= CHAR_ZERO && rsp_text_byte <= CHAR_ZERO + 8'd9))
      else $error("response byte is not a sign or digit, or sign flagged as final");

   // a digit '0' must never come right after a taken minus sign
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_text_byte == CHAR_MINUS
      ##1 rsp_valid && rsp_text_byte == CHAR_ZERO |-> 1'b0)
      else $error("leading zero after minus sign");

   // no response straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_number     (req_number),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_byte  (rsp_text_byte),
   .rsp_final_byte (rsp_final_byte)
);
